// ===== rtl/core/csv_quoted_field_tokenizer_assert.svh =====
// Assertion macros for the CSV field tokenizer.
`ifndef CSV_QUOTED_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_QUOTED_FIELD_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CQFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define CQFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define CQFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CQFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/cqft_pkg.sv =====
`default_nettype none

package cqft_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_AFTER_Q  = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       field_end;
    logic       record_end;
    logic [1:0] error_code;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/cqft_step.sv =====
`default_nettype none

module cqft_step import cqft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire in_word_t  word_i,
  output out_word_t      result_o
);

`include "csv_quoted_field_tokenizer_assert.svh"

  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_QUOTED  = 3'd1,
    MODE_PENDING = 3'd2,
    MODE_DISCARD = 3'd3
  } mode_e;

  mode_e      mode_q, mode_d;
  logic       empty_q, empty_d;
  logic [1:0] held_q, held_d;
  out_word_t  res;

  always_comb begin
    mode_d = mode_q;
    empty_d = empty_q;
    held_d = held_q;
    res = '0;
    if (word_i.line_end) begin
      res.record_end = 1'b1;
      case (mode_q)
        MODE_PLAIN, MODE_PENDING: res.field_end = 1'b1;
        MODE_QUOTED:              res.error_code = ERR_UNCLOSED;
        default:                  res.error_code = held_q;
      endcase
      mode_d = MODE_PLAIN;
      empty_d = 1'b1;
      held_d = ERR_NONE;
    end else begin
      case (mode_q)
        MODE_PLAIN: begin
          if (word_i.data_byte == CH_COMMA) begin
            res.field_end = 1'b1;
            empty_d = 1'b1;
          end else if (word_i.data_byte == CH_QUOTE && empty_q) begin
            mode_d = MODE_QUOTED;
          end else begin
            res.byte_valid = 1'b1;
            res.out_byte = word_i.data_byte;
            empty_d = 1'b0;
          end
        end
        MODE_QUOTED: begin
          if (word_i.data_byte == CH_QUOTE) begin
            mode_d = MODE_PENDING;
          end else begin
            res.byte_valid = 1'b1;
            res.out_byte = word_i.data_byte;
            empty_d = 1'b0;
          end
        end
        MODE_PENDING: begin
          if (word_i.data_byte == CH_QUOTE) begin
            res.byte_valid = 1'b1;
            res.out_byte = CH_QUOTE;
            empty_d = 1'b0;
            mode_d = MODE_QUOTED;
          end else if (word_i.data_byte == CH_COMMA) begin
            res.field_end = 1'b1;
            empty_d = 1'b1;
            mode_d = MODE_PLAIN;
          end else begin
            res.error_code = ERR_AFTER_Q;
            held_d = ERR_AFTER_Q;
            mode_d = MODE_DISCARD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      empty_q <= 1'b1;
      held_q <= ERR_NONE;
    end else if (accept_i) begin
      mode_q <= mode_d;
      empty_q <= empty_d;
      held_q <= held_d;
    end
  end

  `CQFT_ASSERT_NEXT(a_line_clears, clk_i, rst_ni, accept_i && word_i.line_end,
    mode_q == MODE_PLAIN && empty_q && held_q == ERR_NONE)
  `CQFT_ASSERT_NEXT(a_err_discards, clk_i, rst_ni,
    accept_i && !word_i.line_end && res.error_code == ERR_AFTER_Q, mode_q == MODE_DISCARD)
  `CQFT_ASSERT_IMPLY(a_discard_held, clk_i, rst_ni, mode_q == MODE_DISCARD,
    held_q == ERR_AFTER_Q)
  `CQFT_ASSERT_IMPLY(a_quoted_nonempty, clk_i, rst_ni,
    mode_q == MODE_PENDING && !word_i.line_end && word_i.data_byte == CH_QUOTE,
    res.byte_valid && res.out_byte == CH_QUOTE)

endmodule

`default_nettype wire

// ===== rtl/core/cqft_out_reg.sv =====
`default_nettype none

module cqft_out_reg import cqft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire logic      drain_i,
  input  wire out_word_t word_i,
  output logic           full_o,
  output out_word_t      word_o
);

  logic      valid_q;
  out_word_t word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (drain_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign full_o = valid_q;
  assign word_o = word_q;

endmodule

`default_nettype wire

// ===== rtl/core/csv_quoted_field_tokenizer.sv =====
`default_nettype none

// CSV field tokenizer: one byte word per clock in, one result word per input word out,
// registered on acceptance. The parse state update and the result decode sit in one
// short stage ahead of a single result register, so throughput is one word per cycle;
// input stall rises only while that register holds a word that the output side stalls.

module csv_quoted_field_tokenizer import cqft_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  logic      accept;
  logic      drain;
  logic      full;
  out_word_t result;

  assign in_stall_o = full && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;
  assign drain = full && !out_stall_i;

  cqft_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_word_i),
    .result_o (result)
  );

  cqft_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .drain_i (drain),
    .word_i  (result),
    .full_o  (full),
    .word_o  (out_word_o)
  );

  assign out_valid_o = full;

endmodule

`default_nettype wire
